// ===== sv/lin_master_frame_encoder_unit_macros.svh =====
// Assertion macros used by the checker of the LIN master frame encoder.
`ifndef LIN_MASTER_FRAME_ENCODER_UNIT_MACROS_SVH
`define LIN_MASTER_FRAME_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while arst_n is low.
`define LMFE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("LIN frame encoder check failed");

// Next-cycle implication, sampled on clk and quiet while arst_n is low.
`define LMFE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("LIN frame encoder check failed");

`endif

// ===== sv/lmfe_pkg.sv =====
// Types, constants and helper functions of the LIN master frame encoder.
`timescale 1ns / 1ps

package lmfe_pkg;

	localparam logic [7:0] BREAK_BYTE = 8'h00;
	localparam logic [7:0] SYNC_BYTE  = 8'h55;
	localparam int         NUM_DATA   = 8;
	localparam int         IDX_W      = $clog2(NUM_DATA);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_BREAK,
		ST_SYNC,
		ST_PID,
		ST_DATA,
		ST_CKSUM
	} state_t;

	typedef enum logic [2:0] {
		SRC_BREAK,
		SRC_SYNC,
		SRC_PID,
		SRC_DATA,
		SRC_CKSUM
	} src_t;

	typedef struct packed {
		logic strobe;
		src_t src;
		logic accumulate;
		logic load;
	} ctrl_t;

	// Protected identifier: parity P0 in bit 6, inverted parity P1 in bit 7.
	function automatic logic [7:0] protect_id(input logic [5:0] id);
		logic p0;
		logic p1;
		p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
		p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
		return {p1, p0, id};
	endfunction

	// Index of the last data byte for a nonzero length code (1, 3 or 7).
	function automatic logic [IDX_W-1:0] last_index(input logic [1:0] code);
		return {code == 2'd3, code[1], 1'b1};
	endfunction

endpackage

// ===== sv/lmfe_eac_unit.sv =====
// Shared end-around-carry byte adder used for the checksum accumulation.
`timescale 1ns / 1ps

module lmfe_eac_unit (
	input  logic [7:0] acc,
	input  logic [7:0] operand,
	output logic [7:0] sum
);

	logic [8:0] raw;

	// A carry out of bit 7 is folded back in, which is the same as taking 255 off.
	assign raw = {1'b0, acc} + {1'b0, operand};
	assign sum = raw[7:0] + {7'd0, raw[8]};

endmodule

// ===== sv/lmfe_seq.sv =====
// Sequencer that walks one frame request through its transmit bytes.
`timescale 1ns / 1ps

module lmfe_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         length_code,
	output logic               busy,
	output lmfe_pkg::ctrl_t    ctrl
);

	import lmfe_pkg::*;

	state_t            state_q;
	state_t            state_next;
	logic [1:0]        len_q;
	logic [IDX_W-1:0]  cnt_q;
	logic              load;

	// The checksum cycle is the last of a frame, so a new request may start there.
	assign busy = (state_q != ST_IDLE) && (state_q != ST_CKSUM);
	assign load = start && !busy;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE:  state_next = load ? ST_BREAK : ST_IDLE;
			ST_BREAK: state_next = ST_SYNC;
			ST_SYNC:  state_next = ST_PID;
			ST_PID:   state_next = (len_q == 2'd0) ? ST_CKSUM : ST_DATA;
			ST_DATA:  state_next = (cnt_q == last_index(len_q)) ? ST_CKSUM : ST_DATA;
			ST_CKSUM: state_next = load ? ST_BREAK : ST_IDLE;
			default:  state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl            = '0;
		ctrl.load       = load;
		ctrl.strobe     = (state_q != ST_IDLE);
		ctrl.accumulate = (state_q == ST_DATA);
		case (state_q)
			ST_BREAK: ctrl.src = SRC_BREAK;
			ST_SYNC:  ctrl.src = SRC_SYNC;
			ST_PID:   ctrl.src = SRC_PID;
			ST_DATA:  ctrl.src = SRC_DATA;
			ST_CKSUM: ctrl.src = SRC_CKSUM;
			default:  ctrl.src = SRC_BREAK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			len_q   <= 2'd0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_next;
			if (load) begin
				len_q <= length_code;
			end
			if (state_q == ST_DATA) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
		end
	end

endmodule

// ===== sv/lin_master_frame_encoder_unit.sv =====
// Top level of the LIN master frame encoder: request capture, byte shifter and output select.
`timescale 1ns / 1ps
// The break word appears on the cycle after start is taken, then one word per cycle.
// A frame with n data bytes gives 4 + n words (4 to 12) in consecutive cycles.
// The sequencer steps one word per cycle and takes a new request only in idle or on the checksum word.
// busy drops during the checksum cycle, so the next request may follow without a gap.
// Reset (arst_n low, asynchronous) returns the sequencer to idle with no word pending.

module lin_master_frame_encoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [5:0] frame_id,
	input  logic [1:0] length_code,
	input  logic       enhanced_checksum,
	input  logic [7:0] data_byte_0,
	input  logic [7:0] data_byte_1,
	input  logic [7:0] data_byte_2,
	input  logic [7:0] data_byte_3,
	input  logic [7:0] data_byte_4,
	input  logic [7:0] data_byte_5,
	input  logic [7:0] data_byte_6,
	input  logic [7:0] data_byte_7,
	output logic       strobe,
	output logic [7:0] tx_byte,
	output logic       at_break_rate,
	output logic       last_of_frame
);

	import lmfe_pkg::*;

	ctrl_t      ctrl;
	logic [7:0] pid_q;
	logic [7:0] sum_q;
	logic [7:0] sum_next;
	logic [7:0] data_q [NUM_DATA];
	logic [7:0] pid_in;

	// The sequencer owns the frame position; the datapath below only follows its controls.
	lmfe_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.length_code (length_code),
		.busy        (busy),
		.ctrl        (ctrl)
	);

	// One adder serves every data byte: the running sum and the byte at the shifter head.
	lmfe_eac_unit u_eac (
		.acc     (sum_q),
		.operand (data_q[0]),
		.sum     (sum_next)
	);

	assign pid_in = protect_id(frame_id);

	// Payload registers. On a request they capture the data bytes and seed the checksum with
	// the protected identifier in enhanced mode or with zero in classic mode. While data
	// words go out, the bytes shift toward the head, which is both the output and the adder
	// operand. Bytes past the length code are simply never shifted out.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			pid_q     <= pid_in;
			sum_q     <= enhanced_checksum ? pid_in : 8'h00;
			data_q[0] <= data_byte_0;
			data_q[1] <= data_byte_1;
			data_q[2] <= data_byte_2;
			data_q[3] <= data_byte_3;
			data_q[4] <= data_byte_4;
			data_q[5] <= data_byte_5;
			data_q[6] <= data_byte_6;
			data_q[7] <= data_byte_7;
		end else if (ctrl.accumulate) begin
			sum_q <= sum_next;
			for (int i = 0; i < NUM_DATA - 1; i++) begin
				data_q[i] <= data_q[i + 1];
			end
			data_q[NUM_DATA - 1] <= 8'h00;
		end
	end

	// The output word comes straight from registers through one select, so each word is
	// valid for exactly the cycle in which strobe is high.
	always_comb begin
		case (ctrl.src)
			SRC_BREAK: tx_byte = BREAK_BYTE;
			SRC_SYNC:  tx_byte = SYNC_BYTE;
			SRC_PID:   tx_byte = pid_q;
			SRC_DATA:  tx_byte = data_q[0];
			SRC_CKSUM: tx_byte = ~sum_q;
			default:   tx_byte = BREAK_BYTE;
		endcase
	end

	assign strobe        = ctrl.strobe;
	assign at_break_rate = ctrl.strobe && (ctrl.src == SRC_BREAK);
	assign last_of_frame = ctrl.strobe && (ctrl.src == SRC_CKSUM);

endmodule

// ===== sv/lmfe_checker.sv =====
// Port-level checker for the LIN master frame encoder, bound to the top level.
`timescale 1ns / 1ps
`include "lin_master_frame_encoder_unit_macros.svh"

module lmfe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       strobe,
	input logic [7:0] tx_byte,
	input logic       at_break_rate,
	input logic       last_of_frame
);

	// A taken request always opens with the break word on the next cycle.
	`LMFE_ASSERT_NEXT(a_start_break, start && !busy, strobe && at_break_rate)
	// The break word is zero and never also ends the frame.
	`LMFE_ASSERT_NOW(a_break_word, at_break_rate, strobe && tx_byte == 8'h00 && !last_of_frame)
	// Sync follows break directly.
	`LMFE_ASSERT_NEXT(a_sync_after_break, strobe && at_break_rate, strobe && tx_byte == 8'h55)
	// While a frame is in progress a word goes out every cycle.
	`LMFE_ASSERT_NOW(a_busy_emits, busy, strobe && !last_of_frame)
	// Without a new request the frame's last word is followed by silence.
	`LMFE_ASSERT_NEXT(a_quiet_after_last, last_of_frame && !start, !strobe && !busy)

endmodule

bind lin_master_frame_encoder_unit lmfe_checker u_lmfe_checker (.*);

// ===== bench/lin_master_frame_encoder_unit_test.sv =====
// Self-checking testbench of the LIN master frame encoder: directed and random frame requests.
`timescale 1ns / 1ps

module lin_master_frame_encoder_unit_test;

	// One frame request as presented on the request ports.
	typedef struct packed {
		logic [5:0]      id;
		logic [1:0]      len_code;
		logic            enhanced;
		logic [7:0][7:0] data;
	} frame_req_t;

	// One transmitted word: the byte and its two flags.
	typedef struct packed {
		logic [7:0] tx;
		logic       brk;
		logic       last;
	} frame_word_t;

	// Keeps the words that the encoder still owes us, in transmit order, and
	// compares each word that comes out against the oldest of them.
	class lin_frame_scoreboard;
		frame_word_t expected_words[$];
		int          mismatches;

		function new();
			mismatches = 0;
		endfunction

		// Identifier with P0 in bit 6 and the inverted P1 in bit 7.
		function logic [7:0] protected_id(input logic [5:0] id);
			logic p0;
			logic p1;
			p0 = ^{id[4], id[2], id[1], id[0]};
			p1 = !(^{id[5], id[4], id[3], id[1]});
			return {p1, p0, id};
		endfunction

		function int data_count(input logic [1:0] len_code);
			case (len_code)
				2'd0: return 0;
				2'd1: return 2;
				2'd2: return 4;
				default: return 8;
			endcase
		endfunction

		// Works out the whole word sequence of an accepted request.
		function void note_request(input frame_req_t req);
			logic [7:0] pid;
			logic [8:0] sum;
			int         n;
			pid = protected_id(req.id);
			n = data_count(req.len_code);
			sum = req.enhanced ? {1'b0, pid} : 9'd0;
			expected_words.push_back('{tx: 8'h00, brk: 1'b1, last: 1'b0});
			expected_words.push_back('{tx: 8'h55, brk: 1'b0, last: 1'b0});
			expected_words.push_back('{tx: pid, brk: 1'b0, last: 1'b0});
			for (int i = 0; i < n; i++) begin
				expected_words.push_back('{tx: req.data[i], brk: 1'b0, last: 1'b0});
				// End-around carry: a sum past 255 wraps back by 255.
				sum = sum + {1'b0, req.data[i]};
				if (sum > 9'd255) begin
					sum = sum - 9'd255;
				end
			end
			expected_words.push_back('{tx: ~sum[7:0], brk: 1'b0, last: 1'b1});
		endfunction

		function int pending();
			return expected_words.size();
		endfunction

		task report_mismatch(input string msg);
			mismatches++;
			$display("%0t ns: mismatch: %s", $time, msg);
		endtask

		task check_word(input logic [7:0] tx, input logic brk, input logic last);
			frame_word_t want;
			if (expected_words.size() == 0) begin
				report_mismatch($sformatf("unexpected word %02h brk=%b last=%b", tx, brk, last));
				return;
			end
			want = expected_words.pop_front();
			if (tx !== want.tx) begin
				report_mismatch($sformatf("tx_byte %02h, expected %02h", tx, want.tx));
			end
			if (brk !== want.brk) begin
				report_mismatch($sformatf("at_break_rate %b, expected %b", brk, want.brk));
			end
			if (last !== want.last) begin
				report_mismatch($sformatf("last_of_frame %b, expected %b", last, want.last));
			end
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic [5:0] frame_id = '0;
	logic [1:0] length_code = '0;
	logic       enhanced_checksum = 1'b0;
	logic [7:0] data_byte_0 = '0;
	logic [7:0] data_byte_1 = '0;
	logic [7:0] data_byte_2 = '0;
	logic [7:0] data_byte_3 = '0;
	logic [7:0] data_byte_4 = '0;
	logic [7:0] data_byte_5 = '0;
	logic [7:0] data_byte_6 = '0;
	logic [7:0] data_byte_7 = '0;
	logic       strobe;
	logic [7:0] tx_byte;
	logic       at_break_rate;
	logic       last_of_frame;

	lin_frame_scoreboard frame_board = new();

	// Chance in percent that the request side adds one more idle cycle, start low, before a request.
	int sender_idle_pct = 0;

	lin_master_frame_encoder_unit u_dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.start             (start),
		.busy              (busy),
		.frame_id          (frame_id),
		.length_code       (length_code),
		.enhanced_checksum (enhanced_checksum),
		.data_byte_0       (data_byte_0),
		.data_byte_1       (data_byte_1),
		.data_byte_2       (data_byte_2),
		.data_byte_3       (data_byte_3),
		.data_byte_4       (data_byte_4),
		.data_byte_5       (data_byte_5),
		.data_byte_6       (data_byte_6),
		.data_byte_7       (data_byte_7),
		.strobe            (strobe),
		.tx_byte           (tx_byte),
		.at_break_rate     (at_break_rate),
		.last_of_frame     (last_of_frame)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Every strobed word is taken at the edge that ends its cycle. Outputs are
	// read at the edge itself, before the block's registers move on.
	always @(posedge clk) begin
		if (arst_n && strobe !== 1'b0) begin
			frame_board.check_word(tx_byte, at_break_rate, last_of_frame);
		end
	end

	// Presents one request and holds it until the edge where busy is low.
	// The random idle gap comes first, so back-to-back requests keep start
	// high across the handover without lowering it in between.
	task send_frame(input frame_req_t req);
		int gap;
		gap = 0;
		while (gap < 24 && $urandom_range(99) < sender_idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		frame_id <= req.id;
		length_code <= req.len_code;
		enhanced_checksum <= req.enhanced;
		data_byte_0 <= req.data[0];
		data_byte_1 <= req.data[1];
		data_byte_2 <= req.data[2];
		data_byte_3 <= req.data[3];
		data_byte_4 <= req.data[4];
		data_byte_5 <= req.data[5];
		data_byte_6 <= req.data[6];
		data_byte_7 <= req.data[7];
		do begin
			@(posedge clk);
		end while (busy !== 1'b0);
		frame_board.note_request(req);
	endtask

	// Drops start and waits until every owed word has come out.
	task drain_frames();
		start <= 1'b0;
		do begin
			@(posedge clk);
		end while (frame_board.pending() != 0);
	endtask

	function frame_req_t make_frame(input logic [5:0] id, input logic [1:0] len_code,
			input logic enhanced, input logic [7:0] fill);
		frame_req_t req;
		req.id = id;
		req.len_code = len_code;
		req.enhanced = enhanced;
		for (int i = 0; i < 8; i++) begin
			req.data[i] = fill;
		end
		return req;
	endfunction

	// Random request; now and then the data saturates so the carry path
	// wraps on almost every byte, or stays at zero.
	function frame_req_t random_frame();
		frame_req_t req;
		int         flavor;
		flavor = $urandom_range(15);
		req.id = 6'($urandom_range(63));
		req.len_code = 2'($urandom_range(3));
		req.enhanced = 1'($urandom_range(1));
		for (int i = 0; i < 8; i++) begin
			case (flavor)
				0: req.data[i] = 8'hff;
				1: req.data[i] = 8'h00;
				2: req.data[i] = 8'h80 | 8'($urandom_range(255));
				default: req.data[i] = 8'($urandom_range(255));
			endcase
		end
		return req;
	endfunction

	initial begin
		frame_req_t req;
		int         phase_idle[4];
		phase_idle = '{0, 78, 38, 0};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Empty frames in both modes: classic gives 0xFF,
		// enhanced gives the inverted protected identifier.
		send_frame(make_frame(6'h00, 2'd0, 1'b0, 8'h00));
		send_frame(make_frame(6'h00, 2'd0, 1'b1, 8'h00));
		send_frame(make_frame(6'h3f, 2'd0, 1'b1, 8'hff));
		// Full frames of 0xFF wrap on every byte (in classic mode from the second on); a zero frame never wraps.
		send_frame(make_frame(6'h3f, 2'd3, 1'b0, 8'hff));
		send_frame(make_frame(6'h3f, 2'd3, 1'b1, 8'hff));
		send_frame(make_frame(6'h00, 2'd3, 1'b0, 8'h00));
		// Sums that land exactly on 256 wrap to one.
		send_frame(make_frame(6'h15, 2'd2, 1'b0, 8'h80));
		// Bytes past the length code must be ignored.
		send_frame(make_frame(6'h2a, 2'd1, 1'b1, 8'haa));
		send_frame(make_frame(6'h3c, 2'd2, 1'b1, 8'h01));
		req = make_frame(6'h23, 2'd3, 1'b1, 8'h55);
		req.data[1] = 8'haa;
		req.data[3] = 8'haa;
		req.data[5] = 8'haa;
		req.data[7] = 8'haa;
		send_frame(req);
		// Single-bit identifiers exercise each parity term on its own.
		for (int b = 0; b < 6; b++) begin
			send_frame(make_frame(6'h01 << b, b[1:0], b[0], 8'h7f));
		end

		// At least one full stop: nothing is offered until the queue empties.
		drain_frames();

		for (int p = 0; p < 4; p++) begin
			sender_idle_pct = phase_idle[p];
			for (int k = 0; k < 80; k++) begin
				send_frame(random_frame());
			end
			drain_frames();
		end

		// Let any trailing word show up before the verdict.
		repeat (16) @(posedge clk);
		if (frame_board.mismatches == 0 && frame_board.pending() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
